FILE: sv/tgal_pkg.sv
package tgal_pkg;

   localparam int GLYPH_BUFFER_BYTES_DEF = 4096;
   localparam int QUEUE_DEPTH = 4;

   localparam int BYTE_W   = 8;
   localparam int ADDR_W   = 20;
   localparam int CNT_W    = 7;
   localparam int WIDTH_W  = 5;
   localparam int FILL_W   = 13;
   localparam int XPOS_W   = 13;
   localparam int COUNT_W  = 9;
   localparam int INDEX_W  = 14;
   localparam int STATUS_W = 2;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 3;

   localparam logic [BYTE_W-1:0] CODE_BASE = 8'hA1;
   localparam logic [6:0]        ROW_CELLS = 7'd94;

   typedef enum logic [1:0] {
      OP_ASCII,
      OP_HANZI,
      OP_BAD,
      OP_END
   } op_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2,
      ST_END  = 2'd3
   } status_type;

   typedef enum logic {
      BK_IDLE,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      op_kind_type       kind;
      logic              big;
      logic [BYTE_W-1:0] lead;
      logic [BYTE_W-1:0] trail;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [CNT_W-1:0] glyph_bytes(input logic hanzi, input logic big);
      logic [CNT_W-1:0] r;
      begin
         if (hanzi) r = big ? 7'd72 : 7'd32;
         else       r = big ? 7'd48 : 7'd16;
         return r;
      end
   endfunction

   function automatic logic [WIDTH_W-1:0] glyph_px(input logic hanzi, input logic big);
      logic [WIDTH_W-1:0] r;
      begin
         if (hanzi) r = big ? 5'd24 : 5'd16;
         else       r = big ? 5'd16 : 5'd8;
         return r;
      end
   endfunction

endpackage

FILE: sv/tgal_front.sv
module tgal_front
   import tgal_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [BYTE_W-1:0]  req_tdata,   // text_byte
   input  logic               font_big,
   input  queue_status_type   q_status,
   output push_type           push
);

   logic              lead_pending_ff, lead_pending_in;
   logic [BYTE_W-1:0] lead_value_ff, lead_value_in;
   logic              accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_pending_ff <= 1'b0;
         lead_value_ff   <= '0;
      end else begin
         lead_pending_ff <= lead_pending_in;
         lead_value_ff   <= lead_value_in;
      end
   end

   always_comb begin
      req_tready      = !q_status.full;
      accept          = req_tvalid && req_tready;
      lead_pending_in = lead_pending_ff;
      lead_value_in   = lead_value_ff;
      push.valid      = 1'b0;
      push.op.kind    = OP_ASCII;
      push.op.big     = font_big;
      push.op.lead    = lead_value_ff;
      push.op.trail   = req_tdata;
      if (accept) begin
         if (req_tdata == '0) begin
            push.valid      = 1'b1;
            push.op.kind    = OP_END;
            lead_pending_in = 1'b0;
            lead_value_in   = '0;
         end else if (lead_pending_ff) begin
            // pair the held lead with this trail beat
            push.valid      = 1'b1;
            push.op.kind    = (lead_value_ff < CODE_BASE || req_tdata < CODE_BASE)
                              ? OP_BAD : OP_HANZI;
            lead_pending_in = 1'b0;
         end else if (req_tdata[BYTE_W-1]) begin
            lead_pending_in = 1'b1;
            lead_value_in   = req_tdata;
         end else begin
            push.valid      = 1'b1;
            push.op.kind    = OP_ASCII;
         end
      end
   end

endmodule

FILE: sv/tgal_queue.sv
module tgal_queue
   import tgal_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop,
   output op_type           head,
   output queue_status_type status
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   op_type            slot_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]   count_ff;
   logic              do_push, do_pop;

   assign status.full  = (count_ff == CntW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push.valid && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push)
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop)
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

FILE: sv/tgal_back.sv
module tgal_back
   import tgal_pkg::*;
#(
   parameter int GLYPH_BUFFER_BYTES = GLYPH_BUFFER_BYTES_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  op_type                head,
   input  queue_status_type      q_status,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   localparam int BufW = $clog2(GLYPH_BUFFER_BYTES + 1);
   localparam int SumW = ((BufW > FILL_W) ? BufW : FILL_W) + 1;

   back_state_type     state_ff, state_in;
   op_type             op_ff, op_in;
   logic [INDEX_W-1:0] index_ff, index_in;

   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [XPOS_W-1:0]  x_ff, x_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic               halted_ff, halted_in;

   logic               valid_ff, valid_in;
   logic               kind_ff, kind_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [WIDTH_W-1:0] width_ff, width_in;
   logic [FILL_W-1:0]  off_ff, off_in;
   logic [XPOS_W-1:0]  xpos_ff, xpos_in;
   logic [COUNT_W-1:0] num_ff, num_in;
   status_type         status_ff, status_in;

   logic               is_hanzi;
   logic [CNT_W-1:0]   g_cnt;
   logic [WIDTH_W-1:0] g_width;
   logic [INDEX_W+CNT_W-1:0] product;
   logic [FILL_W-1:0]  next_fill;
   logic [SumW-1:0]    headroom;
   logic               slot_free;
   logic [6:0]         row;
   logic [13:0]        row_base;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, num_ff, xpos_ff, off_ff, width_ff, cnt_ff, addr_ff};
   assign rsp_tuser  = {status_ff, kind_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         fill_ff   <= '0;
         x_ff      <= '0;
         total_ff  <= '0;
         halted_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         x_ff      <= x_in;
         total_ff  <= total_in;
         halted_ff <= halted_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      index_ff  <= index_in;
      kind_ff   <= kind_in;
      addr_ff   <= addr_in;
      cnt_ff    <= cnt_in;
      width_ff  <= width_in;
      off_ff    <= off_in;
      xpos_ff   <= xpos_in;
      num_ff    <= num_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      index_in  = index_ff;
      fill_in   = fill_ff;
      x_in      = x_ff;
      total_in  = total_ff;
      halted_in = halted_ff;
      valid_in  = valid_ff && !rsp_tready;
      kind_in   = kind_ff;
      addr_in   = addr_ff;
      cnt_in    = cnt_ff;
      width_in  = width_ff;
      off_in    = off_ff;
      xpos_in   = xpos_ff;
      num_in    = num_ff;
      status_in = status_ff;
      pop       = 1'b0;

      is_hanzi  = (op_ff.kind == OP_HANZI);
      g_cnt     = glyph_bytes(is_hanzi, op_ff.big);
      g_width   = glyph_px(is_hanzi, op_ff.big);
      product   = {7'd0, index_ff} * {14'd0, g_cnt};
      next_fill = fill_ff + FILL_W'(g_cnt);
      headroom  = SumW'(next_fill) + SumW'(glyph_bytes(1'b1, op_ff.big));
      slot_free = !valid_ff || rsp_tready;

      // step one: glyph number within the font (row times cells plus column)
      row       = 7'(head.lead - CODE_BASE);
      row_base  = {7'd0, row} * {7'd0, ROW_CELLS};

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               op_in    = head;
               index_in = (head.kind == OP_HANZI)
                          ? row_base + {7'd0, 7'(head.trail - CODE_BASE)}
                          : {7'd0, head.trail[6:0]};
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (halted_ff && op_ff.kind != OP_END) begin
               // drop beats until the string ends
               state_in = BK_IDLE;
            end else if (slot_free) begin
               valid_in = 1'b1;
               off_in   = fill_ff;
               xpos_in  = x_ff;
               num_in   = total_ff;
               state_in = BK_IDLE;
               case (op_ff.kind)
                  OP_END: begin
                     kind_in   = 1'b0;
                     addr_in   = '0;
                     cnt_in    = '0;
                     width_in  = '0;
                     status_in = ST_END;
                     fill_in   = '0;
                     x_in      = '0;
                     total_in  = '0;
                     halted_in = 1'b0;
                  end
                  OP_BAD: begin
                     kind_in   = 1'b1;
                     addr_in   = '0;
                     cnt_in    = '0;
                     width_in  = '0;
                     status_in = ST_BAD;
                  end
                  default: begin
                     kind_in   = is_hanzi;
                     addr_in   = product[ADDR_W-1:0];
                     cnt_in    = g_cnt;
                     width_in  = g_width;
                     fill_in   = next_fill;
                     x_in      = x_ff + XPOS_W'(g_width);
                     total_in  = total_ff + 1'b1;
                     if (headroom > SumW'(GLYPH_BUFFER_BYTES)) begin
                        status_in = ST_FULL;
                        halted_in = 1'b1;
                     end else begin
                        status_in = ST_OK;
                     end
                  end
               endcase
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

endmodule

FILE: sv/text_glyph_address_layout_core.sv
// Glyph beats pass the op queue and the back end's two steps, one beat at a time: IDLE
// pops a beat and registers its glyph index (multiply), EMIT multiplies it by the glyph
// byte count and registers the result when the output is free; lead bytes give no result.
// A 4-entry op queue lets req_ keep flowing while a result waits on rsp_tready.
// Reset (synchronous, active high) clears the lead, the totals, the queue, the output
// and sets the font size to 16 pixels.
module text_glyph_address_layout_core
   import tgal_pkg::*;
#(
   parameter int GLYPH_BUFFER_BYTES = GLYPH_BUFFER_BYTES_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,   // font_size_select
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,     // text_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rom_address, byte_count, glyph_width, buffer_offset, x_position, glyph_index
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser      // glyph_kind, status
);

   logic             font_big_ff;
   push_type         push;
   op_type           head;
   queue_status_type q_status;
   logic             pop;

   always_ff @(posedge clock) begin
      if (reset)          font_big_ff <= 1'b0;
      else if (csr_wr_en) font_big_ff <= csr_wr_data;
   end

   tgal_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .font_big   (font_big_ff),
      .q_status   (q_status),
      .push       (push)
   );

   tgal_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   tgal_back #(.GLYPH_BUFFER_BYTES(GLYPH_BUFFER_BYTES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: sv/tgal_checker.sv
module tgal_checker
   import tgal_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   logic [CNT_W-1:0] cnt;
   logic [ADDR_W-1:0] addr;
   status_type       st;

   assign addr = rsp_tdata[19:0];
   assign cnt  = rsp_tdata[26:20];
   assign st   = status_type'(rsp_tuser[2:1]);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   a_end_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st == ST_END |-> !rsp_tuser[0] && addr == '0 && cnt == '0)
      else $error("end beat carries glyph data");

   a_bad_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st == ST_BAD |-> rsp_tuser[0] && cnt == '0)
      else $error("bad code beat malformed");

   a_ascii_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] && (st == ST_OK || st == ST_FULL)
      |-> cnt == 7'd16 || cnt == 7'd48)
      else $error("ASCII glyph byte count out of set");

endmodule

bind text_glyph_address_layout_core tgal_checker u_tgal_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
